/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the sorted priority queue RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in every cycle in which ante holds.
`define SPQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("spq assertion failed");

// Check that cons holds in the cycle after ante holds.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("spq assertion failed");

`endif

/* hw/rtl/spq_pkg.sv */
// Package for the sorted priority queue: request and result types, codes.
// Depends on nothing; used by spq_cell and sorted_priority_queue_unit.
package spq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int OCC_W        = 5;

    // Request codes
    localparam logic [1:0] REQ_ENQUEUE = 2'd0;
    localparam logic [1:0] REQ_DEQUEUE = 2'd1;
    localparam logic [1:0] REQ_PEEK    = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] item_value;
        logic signed [15:0] item_priority;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] head_value;
        logic signed [15:0] head_priority;
        logic [OCC_W-1:0]   occupancy;
    } t_rsp;

    typedef struct packed {
        logic signed [31:0] slot_value;
        logic signed [15:0] slot_priority;
    } t_slot;

    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_ctrl;

endpackage

/* hw/rtl/spq_cell.sv */
// One slot of the sorted queue chain: holds a pair, compares it with a new
// request and shifts with its neighbours. Depends on spq_pkg.
module spq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  spq_pkg::t_cell_ctrl i_ctrl,
    input  spq_pkg::t_slot     i_new,
    input  logic               i_keep_prev,
    input  logic               i_keep_self,
    input  spq_pkg::t_slot     i_left,
    input  logic               i_left_valid,
    input  spq_pkg::t_slot     i_right,
    input  logic               i_right_valid,
    output spq_pkg::t_slot     o_slot,
    output logic               o_valid,
    output logic               o_lt,
    output logic               o_le
);

    spq_pkg::t_slot r_slot, n_slot;
    logic           r_valid, n_valid;

    // Compare stored priority with the incoming one; empty slots never match.
    assign o_lt = r_valid && (r_slot.slot_priority <  i_new.slot_priority);
    assign o_le = r_valid && (r_slot.slot_priority <= i_new.slot_priority);

    always_comb begin
        n_slot  = r_slot;
        n_valid = r_valid;
        if (i_ctrl.ins && !i_keep_self) begin
            if (i_keep_prev) begin
                n_slot  = i_new;
                n_valid = 1'b1;
            end else begin
                n_slot  = i_left;
                n_valid = i_left_valid;
            end
        end else if (i_ctrl.del) begin
            n_slot  = i_right;
            n_valid = i_right_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    assign o_slot  = r_slot;
    assign o_valid = r_valid;

endmodule

/* hw/rtl/sorted_priority_queue_unit.sv */
// Sorted priority queue top level: a chain of spq_cell slots plus result
// register. Depends on spq_pkg, spq_cell and assert_macros.svh.
//
// Usage:
//   Drive i_req (request type, value, priority) and raise i_start. A request
//   is taken at each rising edge where i_start is high and o_busy is low;
//   o_busy stays low, so a request may be issued in every cycle.
//   The result appears on o_rsp in the cycle after the request is taken, marked
//   by o_strobe for exactly that cycle: status, head value and priority for
//   a dequeue or peek, and the occupancy after the request.
//   Throughput is 1 request per cycle. Every slot compares
//   its priority with the incoming one in parallel, and the slots shift
//   left or right in one step, so no request ever waits on the chain.
//   Enqueue on a full queue is dropped with overflow status; dequeue or peek
//   on an empty queue returns underflow with zero value and priority.
//   The receiver cannot stall: each result is shown once and then replaced.
//   Reset (synchronous, active low) empties the queue and drops any pending
//   result; slot contents are left as they are and never read while empty.
module sorted_priority_queue_unit #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  spq_pkg::t_req i_req,
    output logic          o_busy,
    output logic          o_strobe,
    output spq_pkg::t_rsp o_rsp
);

    `include "assert_macros.svh"

    localparam int CNT_W = $clog2(CAPACITY + 1);

    spq_pkg::t_slot      w_slot [CAPACITY];
    logic [CAPACITY-1:0] w_valid;
    logic [CAPACITY-1:0] w_lt;
    logic [CAPACITY-1:0] w_le;
    logic [CAPACITY-1:0] w_keep;
    spq_pkg::t_slot      w_new;
    spq_pkg::t_cell_ctrl w_ctrl;

    logic [CNT_W-1:0]       r_count, n_count;
    logic                   r_strobe;
    spq_pkg::t_rsp          r_rsp, n_rsp;
    logic                   w_take;
    logic                   w_empty;
    logic                   w_full;
    logic [CNT_W+spq_pkg::OCC_W-1:0] w_occ_ext;

    // Never hold off a request: no request ever waits on the chain.
    assign o_busy  = 1'b0;
    assign w_take  = i_start && !o_busy;
    assign w_empty = (r_count == '0);
    assign w_full  = (r_count == CNT_W'(CAPACITY));

    assign w_new.slot_value    = i_req.item_value;
    assign w_new.slot_priority = i_req.item_priority;

    // Insertion point: the head stays unless the new priority is smaller;
    // behind the head, slots stay while their priority is strictly smaller.
    always_comb begin
        w_keep[0] = w_le[0];
        for (int i = 1; i < CAPACITY; i++) begin
            w_keep[i] = w_le[0] && w_lt[i];
        end
    end

    always_comb begin
        w_ctrl.ins = w_take && (i_req.req_type == spq_pkg::REQ_ENQUEUE) && !w_full;
        w_ctrl.del = w_take && (i_req.req_type == spq_pkg::REQ_DEQUEUE) && !w_empty;
    end

    // Chain of slots, head at index 0
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        spq_pkg::t_slot w_left, w_right;
        logic           w_left_valid, w_right_valid, w_keep_prev;

        if (g == 0) begin : g_head
            assign w_left       = w_new;
            assign w_left_valid = 1'b1;
            assign w_keep_prev  = 1'b1;
        end else begin : g_body
            assign w_left       = w_slot[g-1];
            assign w_left_valid = w_valid[g-1];
            assign w_keep_prev  = w_keep[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right       = '0;
            assign w_right_valid = 1'b0;
        end else begin : g_inner
            assign w_right       = w_slot[g+1];
            assign w_right_valid = w_valid[g+1];
        end

        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_new         (w_new),
            .i_keep_prev   (w_keep_prev),
            .i_keep_self   (w_keep[g]),
            .i_left        (w_left),
            .i_left_valid  (w_left_valid),
            .i_right       (w_right),
            .i_right_valid (w_right_valid),
            .o_slot        (w_slot[g]),
            .o_valid       (w_valid[g]),
            .o_lt          (w_lt[g]),
            .o_le          (w_le[g])
        );
    end

    // Advance the fill count and build the result of this request.
    always_comb begin
        n_count = r_count;
        if (w_ctrl.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctrl.del) begin
            n_count = r_count - CNT_W'(1);
        end

        w_occ_ext = {{spq_pkg::OCC_W{1'b0}}, n_count};

        n_rsp               = '0;
        n_rsp.status        = spq_pkg::ST_OK;
        n_rsp.occupancy     = w_occ_ext[spq_pkg::OCC_W-1:0];
        unique case (i_req.req_type)
            spq_pkg::REQ_ENQUEUE: begin
                if (w_full) begin
                    n_rsp.status = spq_pkg::ST_OVERFLOW;
                end
            end
            spq_pkg::REQ_DEQUEUE,
            spq_pkg::REQ_PEEK: begin
                if (w_empty) begin
                    n_rsp.status = spq_pkg::ST_UNDERFLOW;
                end else begin
                    n_rsp.head_value    = w_slot[0].slot_value;
                    n_rsp.head_priority = w_slot[0].slot_priority;
                end
            end
            default: begin
                // unused request code: report occupancy only
                n_rsp.status = spq_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_strobe <= w_take;
        end
    end

    // Hold the last result; the strobe marks the cycle in which it is new.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

    // Assertions
    `SPQ_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(CAPACITY))
    `SPQ_ASSERT_IMPL(a_valid_packed, i_clk, i_rst_n, 1'b1,
        w_valid == ({CAPACITY{1'b1}} >> (CAPACITY - int'(r_count))))
    `SPQ_ASSERT_NEXT(a_strobe_follows, i_clk, i_rst_n, w_take, o_strobe)
    `SPQ_ASSERT_IMPL(a_underflow_empty, i_clk, i_rst_n,
        o_strobe && (o_rsp.status == spq_pkg::ST_UNDERFLOW), $past(r_count) == '0)

endmodule
